// ----- src/mbm_pkg.sv -----
package mbm_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BASE  = 2'd1;
    localparam logic [1:0] OP_GLYPH = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BOTTOM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd7;

    // Byte offsets into the combined box: an 11-bit row times an 8-bit pitch.
    localparam int OFF_W = 19;

    typedef struct packed {
        logic take_item;
        logic start;
        logic clr_write;
        logic geo_a;
        logic geo_b;
        logic mul;
        logic addr;
        logic rd_lo;
        logic wr_lo;
        logic wr_hi;
        logic rd_idx;
        logic load_result;
    } mbm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       place;
        logic       clr_last;
    } mbm_status_t;

endpackage

// ----- src/mbm_item_if.sv -----
interface mbm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  source_byte;
    logic [10:0] read_index;

    modport source (output valid, output operation, output source_byte, output read_index,
                    input ready);
    modport sink (input valid, input operation, input source_byte, input read_index,
                  output ready);
endinterface

// ----- src/mbm_result_if.sv -----
interface mbm_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_byte;
    logic signed [10:0] combined_x;
    logic signed [10:0] combined_bottom;
    logic [8:0]         combined_width;
    logic [6:0]         combined_height;
    logic [6:0]         combined_pitch;
    logic               overflow;

    modport source (output valid, output out_byte, output combined_x, output combined_bottom,
                    output combined_width, output combined_height, output combined_pitch,
                    output overflow, input ready);
    modport sink (input valid, input out_byte, input combined_x, input combined_bottom,
                  input combined_width, input combined_height, input combined_pitch,
                  input overflow, output ready);
endinterface

// ----- src/mono_bitmap_merge_blit_unit.sv -----
// Channel  Role    Handshake      Carries
// item     sink    valid/ready    operation, source_byte, read_index
// result   source  valid/ready    out_byte and the combined box, overflow
// cfg      write   cfg_write_en   cfg_index, cfg_data (no handshake back)
//
// A base or glyph byte holds off the next transfer until the read-modify-write
// of two store bytes through the one read port and one write port of the
// store RAM is done; a dropped byte skips it. A read holds ready low until
// its result is loaded, and a start until the whole store is cleared.
// After reset the store is cleared with ready low.
// A waiting result sits in an output register and holds a read only when a
// second result is due before the first is taken.
module mono_bitmap_merge_blit_unit #(
    parameter int MAX_PITCH = 32,
    parameter int MAX_ROWS  = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write_en,
    input logic [mbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [mbm_pkg::CFG_DATA_W-1:0] cfg_data,
    mbm_item_if.sink                      item,
    mbm_result_if.source                  result
);

    localparam int STORE_BYTES = MAX_PITCH * MAX_ROWS;

    mbm_pkg::mbm_cmd_t    cmd;
    mbm_pkg::mbm_status_t status;

    mbm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .operation    (item.operation),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    mbm_dp #(
        .STORE_BYTES(STORE_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (item.operation),
        .source_byte     (item.source_byte),
        .read_index      (item.read_index),
        .out_byte        (result.out_byte),
        .combined_x      (result.combined_x),
        .combined_bottom (result.combined_bottom),
        .combined_width  (result.combined_width),
        .combined_height (result.combined_height),
        .combined_pitch  (result.combined_pitch),
        .overflow        (result.overflow),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

// ----- src/mbm_ram.sv -----
module mbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mbm_ctrl.sv -----
module mbm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           operation,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  mbm_pkg::mbm_status_t status,
    output mbm_pkg::mbm_cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_GEO_A  = 4'd2;
    localparam logic [3:0] S_GEO_B  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_ADDR   = 4'd5;
    localparam logic [3:0] S_RD_LO  = 4'd6;
    localparam logic [3:0] S_WR_LO  = 4'd7;
    localparam logic [3:0] S_WR_HI  = 4'd8;
    localparam logic [3:0] S_RD_IDX = 4'd9;
    localparam logic [3:0] S_RESULT = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (operation == mbm_pkg::OP_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_GEO_A;
                    end
                end
            end
            S_GEO_A:
            begin
                cmd.geo_a  = 1'b1;
                state_next = S_GEO_B;
            end
            S_GEO_B:
            begin
                cmd.geo_b  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                priority if (status.op == mbm_pkg::OP_READ)
                begin
                    state_next = S_RD_IDX;
                end
                else if (status.place)
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                cmd.wr_lo  = 1'b1;
                state_next = S_WR_HI;
            end
            S_WR_HI:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_IDX:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && operation == mbm_pkg::OP_START) |=> state_reg == S_CLEAR)
        else $error("start transfer did not begin a clearing pass");

    a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || result_ready))
        else $error("pending result overwritten");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && status.clr_last) |=> state_reg == S_IDLE)
        else $error("clearing pass did not end after the last address");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_lo |-> $past(cmd.rd_lo))
        else $error("store write without a preceding read");

endmodule

// ----- src/mbm_dp.sv -----
module mbm_dp #(
    parameter int STORE_BYTES = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [mbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [1:0]                       operation,
    input  logic [7:0]                       source_byte,
    input  logic [10:0]                      read_index,
    output logic [7:0]                       out_byte,
    output logic signed [10:0]               combined_x,
    output logic signed [10:0]               combined_bottom,
    output logic [8:0]                       combined_width,
    output logic [6:0]                       combined_height,
    output logic [6:0]                       combined_pitch,
    output logic                             overflow,
    input  mbm_pkg::mbm_cmd_t                cmd,
    output mbm_pkg::mbm_status_t             status
);

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int OFF_W  = mbm_pkg::OFF_W;
    localparam int CMP_W  = OFF_W + 1;
    localparam logic [CMP_W-1:0]  STORE_LIMIT = CMP_W'(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);

    // Configuration registers.
    logic signed [9:0] base_x_reg;
    logic signed [9:0] base_bottom_reg;
    logic [8:0]        base_width_reg;
    logic [6:0]        base_height_reg;
    logic signed [7:0] glyph_gap_reg;
    logic signed [9:0] glyph_bottom_reg;
    logic [8:0]        glyph_width_reg;
    logic [6:0]        glyph_height_reg;

    // Accepted item.
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic [10:0] index_reg;

    // Geometry, first stage.
    logic signed [11:0] x1_ext;
    logic signed [11:0] y1_ext;
    logic signed [11:0] y2_ext;
    logic signed [11:0] dx_next;
    logic signed [11:0] dx_reg;
    logic signed [11:0] wr_next;
    logic signed [11:0] wr_reg;
    logic signed [11:0] x2_next;
    logic signed [11:0] x2_reg;
    logic signed [11:0] t1_next;
    logic signed [11:0] t1_reg;
    logic signed [11:0] t2_next;
    logic signed [11:0] t2_reg;
    logic signed [9:0]  bot_next;
    logic signed [9:0]  bot_reg;

    // Geometry, second stage.
    logic               neg_next;
    logic               neg_reg;
    logic [10:0]        width3_next;
    logic [10:0]        width3_reg;
    logic [11:0]        pitch_sum;
    logic [7:0]         pitch3_next;
    logic [7:0]         pitch3_reg;
    logic signed [10:0] x3_next;
    logic signed [10:0] x3_reg;
    logic signed [11:0] dt;
    logic signed [11:0] top3;
    logic signed [11:0] height_diff;
    logic [10:0]        height3_next;
    logic [10:0]        height3_reg;
    logic signed [11:0] sx_full;
    logic [9:0]         sx_next;
    logic [9:0]         sx_reg;
    logic signed [11:0] sy_full;
    logic [10:0]        sy_next;
    logic [10:0]        sy_reg;
    logic               is_glyph;

    // Raster counters.
    logic              phase_reg;
    logic [6:0]        row_reg;
    logic [5:0]        col_reg;
    logic              phase_v;
    logic [6:0]        row_v;
    logic [6:0]        col_v;
    logic              place_v;
    logic [6:0]        prow_v;
    logic [5:0]        pcol_v;
    logic              active;
    logic [8:0]        bm_width;
    logic [6:0]        bm_height;
    logic [9:0]        bm_pitch_sum;
    logic [6:0]        bm_pitch;
    logic              place_reg;
    logic [6:0]        prow_reg;
    logic [5:0]        pcol_reg;

    // Offset computation and store access.
    logic [10:0]      row_sum;
    logic [10:0]      mul_a;
    logic [OFF_W-1:0] prod_next;
    logic [OFF_W-1:0] prod_reg;
    logic [OFF_W-1:0] n_next;
    logic [OFF_W-1:0] n_reg;
    logic [OFF_W-1:0] n1;
    logic [15:0]      shifted;
    logic [7:0]       v0_reg;
    logic [7:0]       v1_reg;
    logic             ok0_reg;
    logic             ok1_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Result.
    logic       idx_ok;
    logic [8:0] w_sat;
    logic [6:0] h_sat;
    logic [9:0] p_sum;
    logic       ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg       <= '0;
            base_bottom_reg  <= '0;
            base_width_reg   <= '0;
            base_height_reg  <= '0;
            glyph_gap_reg    <= '0;
            glyph_bottom_reg <= '0;
            glyph_width_reg  <= '0;
            glyph_height_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                mbm_pkg::REG_BASE_X:       base_x_reg       <= cfg_data[9:0];
                mbm_pkg::REG_BASE_BOTTOM:  base_bottom_reg  <= cfg_data[9:0];
                mbm_pkg::REG_BASE_WIDTH:   base_width_reg   <= cfg_data[8:0];
                mbm_pkg::REG_BASE_HEIGHT:  base_height_reg  <= cfg_data[6:0];
                mbm_pkg::REG_GLYPH_GAP:    glyph_gap_reg    <= cfg_data[7:0];
                mbm_pkg::REG_GLYPH_BOTTOM: glyph_bottom_reg <= cfg_data[9:0];
                mbm_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[8:0];
                mbm_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[6:0];
                default:                   base_x_reg       <= base_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg    <= operation;
            byte_reg  <= source_byte;
            index_reg <= read_index;
        end
    end

    // First geometry stage: the glyph's offset from the base, the raw combined
    // width and both top edges.
    always_comb
    begin
        x1_ext   = {{2{base_x_reg[9]}}, base_x_reg};
        y1_ext   = {{2{base_bottom_reg[9]}}, base_bottom_reg};
        y2_ext   = {{2{glyph_bottom_reg[9]}}, glyph_bottom_reg};
        dx_next  = {3'b000, base_width_reg} + {{4{glyph_gap_reg[7]}}, glyph_gap_reg};
        wr_next  = dx_next + {3'b000, glyph_width_reg};
        x2_next  = x1_ext + dx_next;
        t1_next  = y1_ext + {5'b00000, base_height_reg};
        t2_next  = y2_ext + {5'b00000, glyph_height_reg};
        bot_next = (base_bottom_reg < glyph_bottom_reg) ? base_bottom_reg : glyph_bottom_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geo_a)
        begin
            dx_reg  <= dx_next;
            wr_reg  <= wr_next;
            x2_reg  <= x2_next;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            bot_reg <= bot_next;
        end
    end

    // Second geometry stage: the box and the pixel shifts of the bitmap in hand.
    always_comb
    begin
        is_glyph     = op_reg == mbm_pkg::OP_GLYPH;
        neg_next     = wr_reg[11];
        width3_next  = neg_next ? 11'd0 : wr_reg[10:0];
        pitch_sum    = {1'b0, width3_next} + 12'd7;
        pitch3_next  = pitch_sum[10:3];
        x3_next      = dx_reg[11] ? x2_reg[10:0] : x1_ext[10:0];
        dt           = t1_reg - t2_reg;
        top3         = dt[11] ? t2_reg : t1_reg;
        height_diff  = top3 - {{2{bot_reg[9]}}, bot_reg};
        height3_next = height_diff[10:0];
        if (is_glyph)
        begin
            sx_full = dx_reg[11] ? 12'sd0 : dx_reg;
            sy_full = dt[11] ? 12'sd0 : dt;
        end
        else
        begin
            sx_full = dx_reg[11] ? -dx_reg : 12'sd0;
            sy_full = dt[11] ? -dt : 12'sd0;
        end
        sx_next = sx_full[9:0];
        sy_next = sy_full[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geo_b)
        begin
            neg_reg     <= neg_next;
            width3_reg  <= width3_next;
            pitch3_reg  <= pitch3_next;
            x3_reg      <= x3_next;
            height3_reg <= height3_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
        end
    end

    // Raster position of the incoming byte within its own bitmap.
    always_comb
    begin
        phase_v      = phase_reg;
        row_v        = row_reg;
        col_v        = {1'b0, col_reg};
        place_v      = 1'b0;
        prow_v       = prow_reg;
        pcol_v       = pcol_reg;
        active       = is_glyph || (op_reg == mbm_pkg::OP_BASE && !phase_reg);
        bm_width     = is_glyph ? glyph_width_reg : base_width_reg;
        bm_height    = is_glyph ? glyph_height_reg : base_height_reg;
        bm_pitch_sum = {1'b0, bm_width} + 10'd7;
        bm_pitch     = bm_pitch_sum[9:3];
        if (is_glyph && !phase_reg)
        begin
            phase_v = 1'b1;
            row_v   = 7'd0;
            col_v   = 7'd0;
        end
        if (active && bm_pitch != 7'd0)
        begin
            if (col_v >= bm_pitch)
            begin
                col_v = 7'd0;
                if (row_v != 7'd127)
                begin
                    row_v = row_v + 7'd1;
                end
            end
            if (row_v < bm_height)
            begin
                place_v = 1'b1;
                prow_v  = row_v;
                pcol_v  = col_v[5:0];
                col_v   = col_v + 7'd1;
                if (col_v >= bm_pitch)
                begin
                    col_v = 7'd0;
                    row_v = row_v + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            place_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            phase_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else if (cmd.geo_b)
        begin
            phase_reg <= phase_v;
            row_reg   <= row_v;
            col_reg   <= col_v[5:0];
            place_reg <= place_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geo_b)
        begin
            prow_reg <= prow_v;
            pcol_reg <= pcol_v;
        end
    end

    // One multiplier: row times pitch for a placement, height times pitch for
    // the capacity check of a read.
    always_comb
    begin
        row_sum   = {4'b0000, prow_reg} + sy_reg;
        mul_a     = (op_reg == mbm_pkg::OP_READ) ? height3_reg : row_sum;
        prod_next = OFF_W'({8'b0, mul_a}) * OFF_W'(pitch3_reg);
        n_next    = prod_reg + OFF_W'(sx_reg[9:3]) + OFF_W'(pcol_reg);
        shifted   = {byte_reg, 8'h00} >> sx_reg[2:0];
        n1        = n_reg + OFF_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.addr)
        begin
            n_reg  <= n_next;
            v0_reg <= shifted[15:8];
            v1_reg <= shifted[7:0];
        end
        if (cmd.rd_lo)
        begin
            ok0_reg <= {1'b0, n_reg} < STORE_LIMIT;
            ok1_reg <= {1'b0, n1} < STORE_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        ram_we = cmd.clr_write || (cmd.wr_lo && ok0_reg) || (cmd.wr_hi && ok1_reg);
        priority if (cmd.clr_write)
        begin
            ram_waddr = clr_addr_reg;
            ram_wdata = 8'h00;
        end
        else if (cmd.wr_lo)
        begin
            ram_waddr = ADDR_W'(n_reg);
            ram_wdata = ram_rdata | v0_reg;
        end
        else
        begin
            ram_waddr = ADDR_W'(n1);
            ram_wdata = ram_rdata | v1_reg;
        end
        ram_re = cmd.rd_lo || cmd.wr_lo || cmd.rd_idx;
        priority if (cmd.rd_lo)
        begin
            ram_raddr = ADDR_W'(n_reg);
        end
        else if (cmd.wr_lo)
        begin
            ram_raddr = ADDR_W'(n1);
        end
        else
        begin
            ram_raddr = ADDR_W'(index_reg);
        end
    end

    mbm_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        idx_ok = CMP_W'(index_reg) < STORE_LIMIT;
        w_sat  = (width3_reg > 11'd511) ? 9'd511 : width3_reg[8:0];
        h_sat  = (height3_reg > 11'd127) ? 7'd127 : height3_reg[6:0];
        p_sum  = {1'b0, w_sat} + 10'd7;
        ovf    = neg_reg || (width3_reg > 11'd511) || (height3_reg > 11'd127)
                 || ({1'b0, prod_reg} > STORE_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_byte        <= idx_ok ? ram_rdata : 8'h00;
            combined_x      <= x3_reg;
            combined_bottom <= {bot_reg[9], bot_reg};
            combined_width  <= w_sat;
            combined_height <= h_sat;
            combined_pitch  <= p_sum[9:3];
            overflow        <= ovf;
        end
    end

    assign status.op       = op_reg;
    assign status.place    = place_reg;
    assign status.clr_last = clr_addr_reg == LAST_ADDR;

endmodule
